@@ design/kps_pkg.sv @@
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants for the serial keypad scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

  localparam int unsigned KeyCount     = 16;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned BitIdxW      = $clog2(MaskW);
  localparam int unsigned BitCntW      = 5;
  localparam int unsigned KeyW         = 5;
  localparam int unsigned IntervalW    = 20;
  localparam int unsigned PhaseW       = 8;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = IntervalW;

  localparam logic [IntervalW-1:0] IntervalMax   = {IntervalW{1'b1}};
  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(8000);
  localparam logic [PhaseW-1:0]    HalfBitReset  = PhaseW'(2);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScanInterval = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHalfBit      = 1'b1;

  typedef enum logic [4:0] {
    SqIdle  = 5'b00001,
    SqStart = 5'b00010,
    SqLow   = 5'b00100,
    SqHigh  = 5'b01000,
    SqTrail = 5'b10000
  } kps_state_e;

  // sequencer result for one tick, taken before the state registers update
  typedef struct packed {
    logic             clock_level;
    logic [MaskW-1:0] cur_mask;
    logic [MaskW-1:0] prev_mask;
    logic             done;
  } kps_seq_t;

endpackage : kps_pkg

`default_nettype wire

@@ design/kps_seq.sv @@
// ----------------------------------------------------------------------------
// kps_seq
// Read sequencer: interval counter, phase timing, bit shifting and the
// current and previous key masks, plus the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [kps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [kps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          step_i,
  input  wire logic                          data_pin_i,
  output kps_pkg::kps_seq_t                  seq_o
);

  logic [kps_pkg::IntervalW-1:0] scan_q;
  logic [kps_pkg::PhaseW-1:0]    half_q;

  kps_pkg::kps_state_e           state_q, state_d;
  logic [kps_pkg::IntervalW-1:0] icnt_q, icnt_d;
  logic [kps_pkg::PhaseW-1:0]    pcnt_q, pcnt_d;
  logic [kps_pkg::BitCntW-1:0]   bcnt_q, bcnt_d;
  logic [kps_pkg::MaskW-1:0]     shift_q, shift_d;
  logic [kps_pkg::MaskW-1:0]     cur_q, cur_d;
  logic [kps_pkg::MaskW-1:0]     prev_q, prev_d;

  kps_pkg::kps_state_e           st;
  logic [kps_pkg::IntervalW-1:0] icnt;
  logic [kps_pkg::PhaseW-1:0]    hb;
  logic [kps_pkg::BitCntW-1:0]   bcnt_inc;
  logic                          start;
  logic                          last;
  logic                          clock_level;
  logic                          done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= kps_pkg::IntervalReset;
      half_q <= kps_pkg::HalfBitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kps_pkg::CfgScanInterval: scan_q <= cfg_data_i;
        kps_pkg::CfgHalfBit:      half_q <= cfg_data_i[kps_pkg::PhaseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hb    = (half_q == '0) ? kps_pkg::PhaseW'(1) : half_q;
    start = (state_q == kps_pkg::SqIdle) && (icnt_q >= scan_q);

    st      = start ? kps_pkg::SqStart : state_q;
    pcnt_d  = start ? '0 : pcnt_q;
    bcnt_d  = start ? '0 : bcnt_q;
    shift_d = start ? '0 : shift_q;
    icnt    = start ? '0 : icnt_q;
    state_d = st;
    cur_d   = cur_q;
    prev_d  = prev_q;
    done    = 1'b0;
    clock_level = 1'b1;
    bcnt_inc    = bcnt_d + kps_pkg::BitCntW'(1);

    // phase ends once its tick count reaches the current length
    last = ({1'b0, pcnt_d} + {1'b0, kps_pkg::PhaseW'(1)}) >= {1'b0, hb};

    if (st != kps_pkg::SqIdle) begin
      clock_level = !((st == kps_pkg::SqStart) || (st == kps_pkg::SqLow));
      if ((st == kps_pkg::SqLow) && last && !data_pin_i &&
          (bcnt_d < kps_pkg::BitCntW'(kps_pkg::MaskW))) begin
        shift_d[bcnt_d[kps_pkg::BitIdxW-1:0]] = 1'b1;
      end
      pcnt_d = pcnt_d + kps_pkg::PhaseW'(1);
      if (last) begin
        pcnt_d = '0;
        unique case (st)
          kps_pkg::SqStart: state_d = kps_pkg::SqLow;
          kps_pkg::SqLow:   state_d = kps_pkg::SqHigh;
          kps_pkg::SqHigh: begin
            bcnt_d  = bcnt_inc;
            state_d = (bcnt_inc >= kps_pkg::BitCntW'(kps_pkg::KeyCount)) ?
                      kps_pkg::SqTrail : kps_pkg::SqLow;
          end
          default: begin
            prev_d  = cur_q;
            cur_d   = shift_d;
            state_d = kps_pkg::SqIdle;
            done    = 1'b1;
          end
        endcase
      end
    end

    icnt_d = (icnt < kps_pkg::IntervalMax) ? icnt + kps_pkg::IntervalW'(1) : icnt;

    seq_o.clock_level = clock_level;
    seq_o.cur_mask    = cur_d;
    seq_o.prev_mask   = prev_d;
    seq_o.done        = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kps_pkg::SqIdle;
      icnt_q  <= '0;
      pcnt_q  <= '0;
      bcnt_q  <= '0;
      shift_q <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      icnt_q  <= icnt_d;
      pcnt_q  <= pcnt_d;
      bcnt_q  <= bcnt_d;
      shift_q <= shift_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
    end
  end

endmodule : kps_seq

`default_nettype wire

@@ design/kps_query.sv @@
// ----------------------------------------------------------------------------
// kps_query
// Per-key flags: pressed, just pressed and just released for one key index.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_query (
  input  wire logic [kps_pkg::KeyW-1:0]  key_index_i,
  input  wire logic [kps_pkg::MaskW-1:0] cur_mask_i,
  input  wire logic [kps_pkg::MaskW-1:0] prev_mask_i,
  output logic                           is_pressed_o,
  output logic                           just_pressed_o,
  output logic                           just_released_o
);

  logic                         in_range;
  logic [kps_pkg::KeyW-1:0]     key_m1;
  logic [kps_pkg::BitIdxW-1:0]  idx;
  logic                         cur_bit;
  logic                         prev_bit;

  always_comb begin
    in_range = (key_index_i != '0) &&
               (key_index_i <= kps_pkg::KeyW'(kps_pkg::KeyCount));
    key_m1   = key_index_i - kps_pkg::KeyW'(1);
    idx      = key_m1[kps_pkg::BitIdxW-1:0];
    cur_bit  = cur_mask_i[idx];
    prev_bit = prev_mask_i[idx];

    is_pressed_o    = in_range & cur_bit;
    just_pressed_o  = in_range & cur_bit & ~prev_bit;
    just_released_o = in_range & ~cur_bit & prev_bit;
  end

endmodule : kps_query

`default_nettype wire

@@ design/serial_keypad_scanner_edges.sv @@
// ----------------------------------------------------------------------------
// serial_keypad_scanner_edges
// Two-wire serial keypad reader, one timebase tick per input beat.
// ----------------------------------------------------------------------------
// an input beat passes the input register, then the result register; one beat
// per cycle while the output is not stalled, set by the single-pass sequencer
// update between the two registers
// reset (async, active low): sequencer idle, counters and masks cleared,
// scan interval 8000 ticks, half bit 2 ticks, both stages empty
`default_nettype none

module serial_keypad_scanner_edges (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          data_pin_i,
  input  wire logic [kps_pkg::KeyW-1:0]      key_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               clock_pin_o,
  output logic [kps_pkg::MaskW-1:0]          key_mask_o,
  output logic                               is_pressed_o,
  output logic                               just_pressed_o,
  output logic                               just_released_o,
  output logic                               snapshot_done_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [kps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [kps_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                      s1_valid_q;
  logic                      s1_data_q;
  logic [kps_pkg::KeyW-1:0]  s1_key_q;

  logic                      out_valid_q;
  logic                      clock_q;
  logic [kps_pkg::MaskW-1:0] mask_q;
  logic                      pressed_q;
  logic                      jp_q;
  logic                      jr_q;
  logic                      done_q;

  logic                      out_free;
  logic                      step;
  logic                      pressed;
  logic                      jp;
  logic                      jr;
  kps_pkg::kps_seq_t         seq;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= data_pin_i;
      s1_key_q  <= key_index_i;
    end
  end

  kps_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .data_pin_i  (s1_data_q),
    .seq_o       (seq)
  );

  kps_query u_query (
    .key_index_i     (s1_key_q),
    .cur_mask_i      (seq.cur_mask),
    .prev_mask_i     (seq.prev_mask),
    .is_pressed_o    (pressed),
    .just_pressed_o  (jp),
    .just_released_o (jr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      clock_q   <= seq.clock_level;
      mask_q    <= seq.cur_mask;
      pressed_q <= pressed;
      jp_q      <= jp;
      jr_q      <= jr;
      done_q    <= seq.done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign clock_pin_o     = clock_q;
  assign key_mask_o      = mask_q;
  assign is_pressed_o    = pressed_q;
  assign just_pressed_o  = jp_q;
  assign just_released_o = jr_q;
  assign snapshot_done_o = done_q;

endmodule : serial_keypad_scanner_edges

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Regression for serial_keypad_scanner_edges. Every timebase tick sent in is
// run through a scan model in this file, and each result beat is compared field
// by field against it, or for the probe rows against a typed result. The run
// covers reset, several timing settings including zero, one and full scale,
// changes of phase length during a read, and random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic             clk_pin;
    logic [MaskW-1:0] mask;
    logic             pressed;
    logic             jpressed;
    logic             jreleased;
    logic             done;
  } tick_res_t;

  typedef struct packed {
    logic            d;
    logic [KeyW-1:0] k;
    tick_res_t       want;
  } probe_row_t;

  // idle after reset: clock high, empty mask, no flags
  localparam tick_res_t IdleRes = '{clk_pin: 1'b1, mask: '0, pressed: 1'b0,
                                    jpressed: 1'b0, jreleased: 1'b0, done: 1'b0};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                data_pin_i = 1'b1;
  logic [KeyW-1:0]     key_index_i = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgScanInterval;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                clock_pin_o;
  logic [MaskW-1:0]    key_mask_o;
  logic                is_pressed_o;
  logic                just_pressed_o;
  logic                just_released_o;
  logic                snapshot_done_o;

  serial_keypad_scanner_edges uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_pin_i      (data_pin_i),
    .key_index_i     (key_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .clock_pin_o     (clock_pin_o),
    .key_mask_o      (key_mask_o),
    .is_pressed_o    (is_pressed_o),
    .just_pressed_o  (just_pressed_o),
    .just_released_o (just_released_o),
    .snapshot_done_o (snapshot_done_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // scanner model state
  logic [IntervalW-1:0] scan_ivl;
  logic [PhaseW-1:0]    half_bit;
  logic [MaskW-1:0]     cur_mask;
  logic [MaskW-1:0]     prev_mask;
  logic [IntervalW-1:0] ivl_cnt;
  logic [PhaseW-1:0]    ph_cnt;
  logic [BitCntW-1:0]   bit_cnt;
  logic [MaskW-1:0]     rx_word;
  kps_state_e           seq_st;
  logic                 clk_lvl;

  tick_res_t   tick_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_stall_pct = 63;
  logic [MaskW-1:0] held_keys = '0;
  logic        last_snapshot = 1'b0;
  int unsigned cycles = 0;

  probe_row_t probe_rows [14] = '{
    '{1'b0, 5'd0,  IdleRes}, '{1'b1, 5'd0,  IdleRes},
    '{1'b0, 5'd1,  IdleRes}, '{1'b1, 5'd1,  IdleRes},
    '{1'b0, 5'd16, IdleRes}, '{1'b1, 5'd16, IdleRes},
    '{1'b0, 5'd17, IdleRes}, '{1'b1, 5'd17, IdleRes},
    '{1'b0, 5'd31, IdleRes}, '{1'b1, 5'd31, IdleRes},
    '{1'b0, 5'd10, IdleRes}, '{1'b1, 5'd21, IdleRes},
    '{1'b0, 5'd5,  IdleRes}, '{1'b1, 5'd14, IdleRes}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void model_reset();
    scan_ivl  = IntervalReset;
    half_bit  = HalfBitReset;
    cur_mask  = '0;
    prev_mask = '0;
    ivl_cnt   = '0;
    ph_cnt    = '0;
    bit_cnt   = '0;
    rx_word   = '0;
    seq_st    = SqIdle;
    clk_lvl   = 1'b1;
  endfunction

  // one timebase tick of the scanner; mask and flags taken after the update
  function automatic tick_res_t scan_tick(logic d, logic [KeyW-1:0] k);
    tick_res_t       r;
    logic [PhaseW:0] hb;
    logic            last;
    logic            c;
    logic            p;
    logic [KeyW-1:0] km1;
    r  = '0;
    hb = (half_bit == '0) ? 9'd1 : {1'b0, half_bit};
    if (seq_st == SqIdle && ivl_cnt >= scan_ivl) begin
      seq_st  = SqStart;
      ph_cnt  = '0;
      bit_cnt = '0;
      rx_word = '0;
      ivl_cnt = '0;
    end
    if (seq_st == SqIdle) begin
      clk_lvl = 1'b1;
    end else begin
      last    = ({1'b0, ph_cnt} + 9'd1) >= hb;
      clk_lvl = (seq_st == SqStart || seq_st == SqLow) ? 1'b0 : 1'b1;
      // sample on the closing tick of a low phase, data is active low
      if (seq_st == SqLow && last && !d && bit_cnt < MaskW) rx_word[bit_cnt[3:0]] = 1'b1;
      ph_cnt = ph_cnt + PhaseW'(1);
      if (last) begin
        ph_cnt = '0;
        case (seq_st)
          SqStart: seq_st = SqLow;
          SqLow:   seq_st = SqHigh;
          SqHigh: begin
            bit_cnt = bit_cnt + BitCntW'(1);
            seq_st  = (bit_cnt >= KeyCount) ? SqTrail : SqLow;
          end
          default: begin
            prev_mask = cur_mask;
            cur_mask  = rx_word;
            seq_st    = SqIdle;
            r.done    = 1'b1;
          end
        endcase
      end
    end
    if (k >= 1 && k <= KeyCount) begin
      km1         = k - KeyW'(1);
      c           = cur_mask[km1[BitIdxW-1:0]];
      p           = prev_mask[km1[BitIdxW-1:0]];
      r.pressed   = c;
      r.jpressed  = c & ~p;
      r.jreleased = ~c & p;
    end
    r.clk_pin = clk_lvl;
    r.mask    = cur_mask;
    if (ivl_cnt != IntervalMax) ivl_cnt = ivl_cnt + IntervalW'(1);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // offer one tick; the model runs on the edge where the beat is taken
  task automatic send_tick(input logic d, input logic [KeyW-1:0] k,
                           input bit typed, input tick_res_t typed_res);
    tick_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    data_pin_i  <= d;
    key_index_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    r = scan_tick(d, k);
    last_snapshot = r.done;
    tick_results_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tick_results_q.size() != 0);
  endtask

  task automatic write_regs(input logic [IntervalW-1:0] ivl, input logic [PhaseW-1:0] hb);
    logic [CfgDataW-1:0] word;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgScanInterval;
    cfg_data_i  <= ivl;
    @(posedge clk_i);
    // unused upper bits of the phase register carry noise
    word             = CfgDataW'($urandom);
    word[PhaseW-1:0] = hb;
    cfg_index_i <= CfgHalfBit;
    cfg_data_i  <= word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scan_ivl = ivl;
    half_bit = hb;
  endtask

  // keypad held in a pattern that changes after each snapshot, with some noise
  task automatic random_tick();
    logic            d;
    logic [KeyW-1:0] k;
    if (bit_cnt < KeyCount && $urandom_range(9) != 0) d = ~held_keys[bit_cnt[3:0]];
    else d = 1'($urandom_range(1));
    k = ($urandom_range(4) == 0) ? KeyW'($urandom_range(31)) : KeyW'($urandom_range(16, 1));
    send_tick(d, k, 1'b0, IdleRes);
    if (last_snapshot) begin
      case ($urandom_range(3))
        0:       held_keys = '0;
        1:       held_keys = '1;
        2:       held_keys = MaskW'(1) << $urandom_range(MaskW - 1);
        default: held_keys = MaskW'($urandom);
      endcase
    end
  endtask

  task automatic run_phase(input logic [IntervalW-1:0] ivl, input logic [PhaseW-1:0] hb,
                           input int unsigned n);
    drain();
    write_regs(ivl, hb);
    repeat (n) random_tick();
  endtask

  always @(posedge clk_i) begin : result_check
    tick_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tick_results_q.size() == 0) begin
        flag_mismatch("result beat with nothing pending", 32'(key_mask_o), '0);
      end else begin
        want = tick_results_q.pop_front();
        if (clock_pin_o !== want.clk_pin)
          flag_mismatch("clock_pin", 32'(clock_pin_o), 32'(want.clk_pin));
        if (key_mask_o !== want.mask)
          flag_mismatch("key_mask", 32'(key_mask_o), 32'(want.mask));
        if (is_pressed_o !== want.pressed)
          flag_mismatch("is_pressed", 32'(is_pressed_o), 32'(want.pressed));
        if (just_pressed_o !== want.jpressed)
          flag_mismatch("just_pressed", 32'(just_pressed_o), 32'(want.jpressed));
        if (just_released_o !== want.jreleased)
          flag_mismatch("just_released", 32'(just_released_o), 32'(want.jreleased));
        if (snapshot_done_o !== want.done)
          flag_mismatch("snapshot_done", 32'(snapshot_done_o), 32'(want.done));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("serial_keypad_scanner_edges regression: fail");
    $finish;
  end

  initial begin
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender 15, receiver 63
    foreach (probe_rows[i]) send_tick(probe_rows[i].d, probe_rows[i].k, 1'b1, probe_rows[i].want);
    run_phase('0, '0, 40);                       // back to back reads, zero phase acts as one
    run_phase(IntervalW'(1), PhaseW'(1), 40);
    run_phase(IntervalW'(40), PhaseW'(3), 50);

    send_idle_pct  = 63;
    recv_stall_pct = 15;
    run_phase(IntervalW'($urandom_range(60)), PhaseW'($urandom_range(4, 1)), 40);
    run_phase(IntervalW'(1), PhaseW'(255), 60);  // stops part way into a long phase
    run_phase(IntervalW'(1), PhaseW'(2), 40);    // phase shrinks below ticks already spent

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(IntervalMax, PhaseW'(2), 30);
    run_phase(IntervalW'(5), PhaseW'(1), 40);    // interval drops under the running count
    run_phase(IntervalW'($urandom_range(100)), PhaseW'($urandom_range(3, 1)), 40);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("serial_keypad_scanner_edges regression: pass");
    end else begin
      $display("serial_keypad_scanner_edges regression: fail");
    end
    $finish;
  end

endmodule
